@@ rtl/dpct_pkg.sv @@
// Shared constants, codes and types of the dense packed component table.
package dpct_pkg;

   localparam int ENTITY_COUNT       = 1024;
   localparam int DATA_WIDTH         = 32;
   localparam int ENTITY_FIELD_WIDTH = 10;
   localparam int CMD_WIDTH          = 2;
   localparam int STATUS_WIDTH       = 2;
   localparam int ENTITY_WIDTH       = $clog2(ENTITY_COUNT);
   localparam int COUNT_WIDTH        = $clog2(ENTITY_COUNT + 1);

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_INSERT  = 2'd0,
      CMD_REMOVE  = 2'd1,
      CMD_GET     = 2'd2,
      CMD_DESTROY = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_DUP     = 2'd1,
      STATUS_MISSING = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic [ENTITY_WIDTH-1:0] entity;
      logic [DATA_WIDTH-1:0]   word;
   } work_type;

   typedef struct packed {
      logic     valid;
      work_type work;
   } head_type;

   typedef struct packed {
      logic                    present;
      logic [ENTITY_WIDTH-1:0] slot;
   } fwd_type;

endpackage

@@ rtl/dpct_if.sv @@
// Request and response channel interfaces.
interface dpct_req_if;
   import dpct_pkg::*;
   logic                          valid;
   logic                          ready;
   logic [CMD_WIDTH-1:0]          command;
   logic [ENTITY_FIELD_WIDTH-1:0] entity;
   logic [DATA_WIDTH-1:0]         component_in;
   modport source (output valid, command, entity, component_in, input ready);
   modport sink   (input valid, command, entity, component_in, output ready);
endinterface

interface dpct_rsp_if;
   import dpct_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [DATA_WIDTH-1:0]   component_out;
   logic [STATUS_WIDTH-1:0] status;
   logic [COUNT_WIDTH-1:0]  entry_count;
   modport source (output valid, component_out, status, entry_count, input ready);
   modport sink   (input valid, component_out, status, entry_count, output ready);
endinterface

@@ rtl/dpct_front.sv @@
// Request intake: decodes requests into a two-entry work queue.
module dpct_front (
   input  logic               clock,
   input  logic               reset,
   dpct_req_if.sink           req_bus,
   input  logic               enable,
   input  logic               pop,
   output dpct_pkg::head_type head
);
   import dpct_pkg::*;

   work_type   entry_ff [2];
   work_type   decoded;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       accept;

   assign req_bus.ready = enable && (fill_ff != 2'd2);
   assign accept        = req_bus.valid && req_bus.ready;

   assign decoded.cmd    = cmd_type'(req_bus.command);
   assign decoded.entity = req_bus.entity[ENTITY_WIDTH-1:0];
   assign decoded.word   = req_bus.component_in;

   assign head.valid = (fill_ff != 2'd0);
   assign head.work  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(accept) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

@@ rtl/dpct_back.sv @@
// Command engine: forward, reverse and data memories, sequencer, response register.
module dpct_back (
   input  logic               clock,
   input  logic               reset,
   input  dpct_pkg::head_type head,
   output logic               pop,
   output logic               init_done,
   dpct_rsp_if.source         rsp_bus
);
   import dpct_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_GETRD,
      ST_DROP
   } state_type;

   state_type               state_ff, state_in;
   work_type                cur_ff, cur_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic [ENTITY_WIDTH-1:0] clr_idx_ff, clr_idx_in;
   logic                    init_done_ff, init_done_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]   rsp_data_ff, rsp_data_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [COUNT_WIDTH-1:0]  rsp_count_ff, rsp_count_in;

   fwd_type                 fwd_mem [ENTITY_COUNT];
   logic [ENTITY_WIDTH-1:0] rev_mem [ENTITY_COUNT];
   logic [DATA_WIDTH-1:0]   data_mem [ENTITY_COUNT];

   logic                    fwd_we, rev_we, data_we;
   logic [ENTITY_WIDTH-1:0] fwd_wa, rev_wa, data_wa;
   logic [ENTITY_WIDTH-1:0] fwd_ra, rev_ra, data_ra;
   fwd_type                 fwd_wd;
   logic [ENTITY_WIDTH-1:0] rev_wd;
   logic [DATA_WIDTH-1:0]   data_wd;
   fwd_type                 fwd_rd_ff;
   logic [ENTITY_WIDTH-1:0] rev_rd_ff;
   logic [DATA_WIDTH-1:0]   data_rd_ff;

   logic [COUNT_WIDTH-1:0]  count_dec;
   logic [ENTITY_WIDTH-1:0] last_slot;
   logic                    out_free;
   logic                    emit;

   assign count_dec = count_ff - COUNT_WIDTH'(1);
   assign last_slot = count_dec[ENTITY_WIDTH-1:0];
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign pop       = (state_ff == ST_IDLE) && head.valid && out_free;
   assign init_done = init_done_ff;

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.component_out = rsp_data_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.entry_count   = rsp_count_ff;

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      count_in      = count_ff;
      clr_idx_in    = clr_idx_ff;
      init_done_in  = init_done_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      emit          = 1'b0;

      fwd_we  = 1'b0;
      fwd_wa  = cur_ff.entity;
      fwd_wd  = '0;
      fwd_ra  = head.work.entity;
      rev_we  = 1'b0;
      rev_wa  = last_slot;
      rev_wd  = cur_ff.entity;
      rev_ra  = last_slot;
      data_we = 1'b0;
      data_wa = last_slot;
      data_wd = cur_ff.word;
      data_ra = last_slot;

      unique case (state_ff)
         ST_CLEAR: begin
            fwd_we     = 1'b1;
            fwd_wa     = clr_idx_ff;
            clr_idx_in = clr_idx_ff + ENTITY_WIDTH'(1);
            if (clr_idx_ff == ENTITY_WIDTH'(ENTITY_COUNT - 1)) begin
               init_done_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (pop) begin
               cur_in   = head.work;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            data_ra = fwd_rd_ff.slot;
            unique case (cur_ff.cmd)
               CMD_INSERT: begin
                  state_in    = ST_IDLE;
                  emit        = 1'b1;
                  rsp_data_in = '0;
                  if (fwd_rd_ff.present || count_ff == COUNT_WIDTH'(ENTITY_COUNT)) begin
                     rsp_status_in = STATUS_DUP;
                  end else begin
                     rsp_status_in  = STATUS_OK;
                     fwd_we         = 1'b1;
                     fwd_wd.present = 1'b1;
                     fwd_wd.slot    = count_ff[ENTITY_WIDTH-1:0];
                     rev_we         = 1'b1;
                     rev_wa         = count_ff[ENTITY_WIDTH-1:0];
                     data_we        = 1'b1;
                     data_wa        = count_ff[ENTITY_WIDTH-1:0];
                     count_in       = count_ff + COUNT_WIDTH'(1);
                  end
               end
               CMD_GET: begin
                  if (fwd_rd_ff.present) begin
                     state_in = ST_GETRD;
                  end else begin
                     state_in      = ST_IDLE;
                     emit          = 1'b1;
                     rsp_data_in   = '0;
                     rsp_status_in = STATUS_MISSING;
                  end
               end
               CMD_REMOVE, CMD_DESTROY: begin
                  if (fwd_rd_ff.present && count_ff != '0) begin
                     // move the last entry into the hole
                     data_we        = 1'b1;
                     data_wa        = fwd_rd_ff.slot;
                     data_wd        = data_rd_ff;
                     rev_we         = 1'b1;
                     rev_wa         = fwd_rd_ff.slot;
                     rev_wd         = rev_rd_ff;
                     fwd_we         = 1'b1;
                     fwd_wa         = rev_rd_ff;
                     fwd_wd.present = 1'b1;
                     fwd_wd.slot    = fwd_rd_ff.slot;
                     count_in       = count_dec;
                     state_in       = ST_DROP;
                  end else begin
                     state_in      = ST_IDLE;
                     emit          = 1'b1;
                     rsp_data_in   = '0;
                     rsp_status_in = (cur_ff.cmd == CMD_REMOVE) ? STATUS_MISSING : STATUS_OK;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_GETRD: begin
            state_in      = ST_IDLE;
            emit          = 1'b1;
            rsp_data_in   = data_rd_ff;
            rsp_status_in = STATUS_OK;
         end
         ST_DROP: begin
            // cleared after the move so a removed last entry ends absent
            fwd_we        = 1'b1;
            state_in      = ST_IDLE;
            emit          = 1'b1;
            rsp_data_in   = '0;
            rsp_status_in = STATUS_OK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         count_ff     <= '0;
         clr_idx_ff   <= '0;
         init_done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         clr_idx_ff   <= clr_idx_in;
         init_done_ff <= init_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff        <= cur_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (fwd_we) begin
         fwd_mem[fwd_wa] <= fwd_wd;
      end
      fwd_rd_ff <= fwd_mem[fwd_ra];
   end

   always_ff @(posedge clock) begin
      if (rev_we) begin
         rev_mem[rev_wa] <= rev_wd;
      end
      rev_rd_ff <= rev_mem[rev_ra];
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[data_wa] <= data_wd;
      end
      data_rd_ff <= data_mem[data_ra];
   end

endmodule

@@ rtl/dense_packed_component_table_unit.sv @@
// Top level of the dense packed component table.
//
//   channel   direction  handshake          payload
//   req_bus   in         valid / ready      command, entity, component_in
//   rsp_bus   out        valid / ready      component_out, status, entry_count
//
// Insert, and a get, remove or destroy of a missing entity, finish in ST_LOOK,
// after the registered read of the forward map; a get, remove or destroy of a
// present entity goes on to ST_GETRD for a dependent data read or to ST_DROP
// for a second forward map write. Each request yields exactly one response.
// After reset the forward map valid bits are cleared one entry per cycle:
// req_bus.ready stays low until the clearing pass is done.
// A two-entry queue takes requests while the engine works; the engine starts
// a request only when the response register is free or draining.
module dense_packed_component_table_unit (
   input  logic       clock,
   input  logic       reset,
   dpct_req_if.sink   req_bus,
   dpct_rsp_if.source rsp_bus
);
   import dpct_pkg::*;

   head_type head;
   logic     pop;
   logic     init_done;

   dpct_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .enable  (init_done),
      .pop     (pop),
      .head    (head)
   );

   dpct_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .init_done (init_done),
      .rsp_bus   (rsp_bus)
   );

endmodule

@@ rtl/dpct_checker.sv @@
// Port-level checks of the dense packed component table and their binding.
module dpct_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [dpct_pkg::DATA_WIDTH-1:0]   rsp_component_out,
   input logic [dpct_pkg::STATUS_WIDTH-1:0] rsp_status,
   input logic [dpct_pkg::COUNT_WIDTH-1:0]  rsp_entry_count
);
   import dpct_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_component_out)
         && $stable(rsp_status) && $stable(rsp_entry_count))
      else $error("response changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_component_out == '0)
      else $error("failed request returned data");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= COUNT_WIDTH'(ENTITY_COUNT))
      else $error("entry count above capacity");

   a_dup_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_DUP |-> rsp_entry_count != '0)
      else $error("duplicate reported on empty table");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("request taken during clearing pass");

endmodule

bind dense_packed_component_table_unit dpct_checker u_dpct_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_component_out (rsp_bus.component_out),
   .rsp_status        (rsp_bus.status),
   .rsp_entry_count   (rsp_bus.entry_count)
);
